@@ design/tdcs_pkg.sv @@
// shared types, constants and calendar functions of the trading day calendar stepper
package tdcs_pkg;

	localparam int HOL_ENTRIES = 32;
	localparam int HOL_AW = (HOL_ENTRIES > 1) ? $clog2(HOL_ENTRIES) : 1;

	localparam logic [13:0] YEAR_MIN = 14'd1900;
	localparam logic [13:0] YEAR_MAX = 14'd9999;
	// leap days counted up to the year before the first year
	localparam logic [13:0] LEAPS_BASE = 14'd460;

	typedef enum logic [2:0] {
		CMD_LOAD = 3'd0,
		CMD_ADD_DAYS = 3'd1,
		CMD_SUB_DAYS = 3'd2,
		CMD_ADD_TRADE = 3'd3,
		CMD_SUB_TRADE = 3'd4,
		CMD_HOL_SET = 3'd5,
		CMD_HOL_CLR = 3'd6,
		CMD_NOP = 3'd7
	} cmd_e;

	typedef struct packed {
		logic [2:0] command;
		logic [13:0] in_year;
		logic [3:0] in_month;
		logic [4:0] in_day;
		logic [9:0] day_count;
		logic [4:0] holiday_slot;
	} req_t;

	typedef struct packed {
		logic [13:0] out_year;
		logic [3:0] out_month;
		logic [4:0] out_day;
		logic [2:0] weekday;
		logic trading_day;
		logic error;
	} rsp_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0] month;
		logic [4:0] day;
	} hol_date_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [2:0] wd;
	} date_t;

	// floor(y / 100) by reciprocal, exact for all 14-bit values
	function automatic logic [7:0] div100(input logic [13:0] y);
		logic [26:0] p;
		p = 27'(y) * 27'd5243;
		return p[26:19];
	endfunction

	function automatic logic is_leap(input logic [13:0] y);
		logic [7:0] q;
		logic [13:0] r;
		q = div100(y);
		r = y - 14'(q) * 14'd100;
		return (y[1:0] == 2'b00) && ((r != 14'd0) || (q[1:0] == 2'b00));
	endfunction

	function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// days of the year before the first of month m
	function automatic logic [8:0] days_before(input logic leap, input logic [3:0] m);
		logic [8:0] n;
		case (m)
			4'd1: n = 9'd0;
			4'd2: n = 9'd31;
			4'd3: n = 9'd59;
			4'd4: n = 9'd90;
			4'd5: n = 9'd120;
			4'd6: n = 9'd151;
			4'd7: n = 9'd181;
			4'd8: n = 9'd212;
			4'd9: n = 9'd243;
			4'd10: n = 9'd273;
			4'd11: n = 9'd304;
			default: n = 9'd334;
		endcase
		if (leap && (m > 4'd2)) begin
			n = n + 9'd1;
		end
		return n;
	endfunction

	function automatic logic date_ok(input logic [13:0] y, input logic [3:0] m,
			input logic [4:0] d);
		return (y >= YEAR_MIN) && (y <= YEAR_MAX) && (m >= 4'd1) && (m <= 4'd12) &&
			(d >= 5'd1) && (d <= month_days(is_leap(y), m));
	endfunction

endpackage

@@ design/tdcs_hol_ram.sv @@
// holiday date memory: one write port, one registered read port
module tdcs_hol_ram (
	input logic clk,
	input logic we,
	input logic [tdcs_pkg::HOL_AW-1:0] waddr,
	input tdcs_pkg::hol_date_t wdata,
	input logic re,
	input logic [tdcs_pkg::HOL_AW-1:0] raddr,
	output tdcs_pkg::hol_date_t rdata
);
	import tdcs_pkg::*;

	hol_date_t mem_q [HOL_ENTRIES];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/tdcs_day_step.sv @@
// one calendar day forward or back, with range check
module tdcs_day_step (
	input tdcs_pkg::date_t cur,
	input logic fwd,
	output tdcs_pkg::date_t nxt,
	output logic ok
);
	import tdcs_pkg::*;

	logic leap;
	logic [4:0] len_cur;
	logic [4:0] len_prev;

	assign leap = is_leap(cur.year);
	assign len_cur = month_days(leap, cur.month);
	assign len_prev = month_days(leap, cur.month - 4'd1);

	// next or previous date
	always_comb begin
		nxt = cur;
		if (fwd) begin
			ok = !((cur.year >= YEAR_MAX) && (cur.month == 4'd12) && (cur.day == 5'd31));
			if (cur.day >= len_cur) begin
				nxt.day = 5'd1;
				if (cur.month >= 4'd12) begin
					nxt.month = 4'd1;
					nxt.year = cur.year + 14'd1;
				end else begin
					nxt.month = cur.month + 4'd1;
				end
			end else begin
				nxt.day = cur.day + 5'd1;
			end
			nxt.wd = (cur.wd >= 3'd6) ? 3'd0 : cur.wd + 3'd1;
		end else begin
			ok = !((cur.year <= YEAR_MIN) && (cur.month == 4'd1) && (cur.day == 5'd1));
			if (cur.day > 5'd1) begin
				nxt.day = cur.day - 5'd1;
			end else if (cur.month <= 4'd1) begin
				nxt.month = 4'd12;
				nxt.day = 5'd31;
				nxt.year = cur.year - 14'd1;
			end else begin
				nxt.month = cur.month - 4'd1;
				nxt.day = len_prev;
			end
			nxt.wd = (cur.wd == 3'd0) ? 3'd6 : cur.wd - 3'd1;
		end
	end

endmodule

@@ design/trading_day_calendar_stepper_core.sv @@
// top level of the trading day calendar stepper: command sequencer and holiday scan
//
// One command goes in on the req channel (req_valid, req_stall, req) and one
// result comes back on the rsp channel (rsp_valid, rsp_stall, rsp) for every
// command. Commands are taken one at a time: req_stall is high from the
// transfer until the result has been written into the output register.
// Every result needs a holiday check of the final date, which reads the
// holiday memory one entry a cycle; a weekend date skips the memory scan.
// A calendar move steps through the days one at a time, and a load works
// out the weekday from the date before the check. A trading move costs one
// check for every date visited, plus the final check, so latency grows with
// the count and the weekends and holidays crossed.
// Results wait in the output register while rsp_stall is high; a new command
// can be taken meanwhile, and its result is held back until the register frees.
// After reset the date is 1900-01-01, a Monday, and all holiday entries are
// invalid; no clearing pass is needed since the valid bits are flip-flops.
module trading_day_calendar_stepper_core (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input tdcs_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output tdcs_pkg::rsp_t rsp
);
	import tdcs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DISP, S_LD1, S_LD2, S_CAL, S_CHK, S_SCAN, S_OUT
	} state_t;

	localparam logic [HOL_AW-1:0] LAST_SLOT = HOL_AW'(HOL_ENTRIES - 1);

	state_t state_q;
	req_t req_q;
	date_t cur_q;
	date_t w_q;
	logic [9:0] cnt_q;
	logic fwd_q;
	logic err_q;
	logic fin_q;
	logic trade_q;
	logic [13:0] ld_x_q;
	logic [HOL_ENTRIES-1:0] hvalid_q;
	logic issuing_q;
	logic [HOL_AW-1:0] ptr_q;
	logic rv_s1;
	logic [HOL_AW-1:0] addr_s1;
	logic hit_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	date_t stp_next;
	logic stp_ok;
	hol_date_t rdata;
	logic slot_ok;
	logic req_date_ok;
	logic ram_we;
	logic ram_re;
	logic match;
	logic weekend;
	logic chk_fire;
	logic chk_trade;
	logic out_load;
	logic [13:0] ld_x;
	logic [13:0] n_prev;
	logic [7:0] q100;
	logic [27:0] prod7;
	logic [11:0] q7;
	logic [13:0] r7;

	tdcs_day_step u_step (
		.cur(w_q),
		.fwd(fwd_q),
		.nxt(stp_next),
		.ok(stp_ok)
	);

	tdcs_hol_ram u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(HOL_AW'(req_q.holiday_slot)),
		.wdata({req_q.in_year, req_q.in_month, req_q.in_day}),
		.re(ram_re),
		.raddr(ptr_q),
		.rdata(rdata)
	);

	// command checks
	assign slot_ok = (32'(req_q.holiday_slot) < HOL_ENTRIES);
	assign req_date_ok = date_ok(req_q.in_year, req_q.in_month, req_q.in_day);
	assign ram_we = (state_q == S_DISP) && (cmd_e'(req_q.command) == CMD_HOL_SET) &&
		slot_ok && req_date_ok;
	assign ram_re = (state_q == S_SCAN) && issuing_q;

	// value equal modulo 7 to the day count since the base date plus one, for the weekday of a load
	assign n_prev = req_q.in_year - 14'd1;
	assign q100 = div100(n_prev);
	assign ld_x = (req_q.in_year - YEAR_MIN) + (n_prev >> 2) - 14'(q100) + 14'(q100 >> 2)
		- LEAPS_BASE + 14'(days_before(is_leap(req_q.in_year), req_q.in_month))
		+ 14'(req_q.in_day);

	// modulo 7 by reciprocal
	assign prod7 = 28'(ld_x_q) * 28'd9363;
	assign q7 = prod7[27:16];
	assign r7 = ld_x_q - 14'(q7) * 14'd7;

	// trading check of the working date
	assign weekend = (w_q.wd == 3'd0) || (w_q.wd == 3'd6);
	assign match = hvalid_q[addr_s1] && (rdata == {w_q.year, w_q.month, w_q.day});
	assign chk_fire = ((state_q == S_CHK) && weekend) ||
		((state_q == S_SCAN) && rv_s1 && (addr_s1 == LAST_SLOT));
	assign chk_trade = (state_q == S_CHK) ? 1'b0 : !(hit_q || match);

	// result enters the output register
	assign out_load = (state_q == S_OUT) && (!rsp_valid_q || !rsp_stall);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q <= '{year: YEAR_MIN, month: 4'd1, day: 5'd1, wd: 3'd1};
			w_q <= '{year: YEAR_MIN, month: 4'd1, day: 5'd1, wd: 3'd1};
			hvalid_q <= '0;
			issuing_q <= 1'b0;
			rv_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			err_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			// output register
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			rv_s1 <= ram_re;
			addr_s1 <= ptr_q;
			if (ram_re) begin
				ptr_q <= ptr_q + HOL_AW'(1);
				if (ptr_q == LAST_SLOT) begin
					issuing_q <= 1'b0;
				end
			end
			if (rv_s1 && match) begin
				hit_q <= 1'b1;
			end

			if (chk_fire) begin
				// decision after a trading check
				if (fin_q) begin
					trade_q <= chk_trade;
					state_q <= S_OUT;
				end else if (!chk_trade || (cnt_q != 10'd0)) begin
					if (chk_trade) begin
						cnt_q <= cnt_q - 10'd1;
					end
					if (stp_ok) begin
						w_q <= stp_next;
						state_q <= S_CHK;
					end else begin
						err_q <= 1'b1;
						w_q <= cur_q;
						fin_q <= 1'b1;
						state_q <= S_CHK;
					end
				end else begin
					cur_q <= w_q;
					fin_q <= 1'b1;
					state_q <= S_CHK;
				end
			end else begin
				case (state_q)
					S_IDLE: begin
						if (req_valid) begin
							req_q <= req;
							err_q <= 1'b0;
							fin_q <= 1'b0;
							w_q <= cur_q;
							state_q <= S_DISP;
						end
					end
					S_DISP: begin
						cnt_q <= req_q.day_count;
						case (cmd_e'(req_q.command))
							CMD_LOAD: begin
								if (req_date_ok) begin
									state_q <= S_LD1;
								end else begin
									err_q <= 1'b1;
									fin_q <= 1'b1;
									state_q <= S_CHK;
								end
							end
							CMD_ADD_DAYS, CMD_SUB_DAYS: begin
								fwd_q <= (cmd_e'(req_q.command) == CMD_ADD_DAYS);
								state_q <= S_CAL;
							end
							CMD_ADD_TRADE, CMD_SUB_TRADE: begin
								fwd_q <= (cmd_e'(req_q.command) == CMD_ADD_TRADE);
								state_q <= S_CHK;
							end
							CMD_HOL_SET: begin
								if (ram_we) begin
									hvalid_q[HOL_AW'(req_q.holiday_slot)] <= 1'b1;
								end else begin
									err_q <= 1'b1;
								end
								fin_q <= 1'b1;
								state_q <= S_CHK;
							end
							CMD_HOL_CLR: begin
								if (slot_ok) begin
									hvalid_q[HOL_AW'(req_q.holiday_slot)] <= 1'b0;
								end else begin
									err_q <= 1'b1;
								end
								fin_q <= 1'b1;
								state_q <= S_CHK;
							end
							default: begin
								fin_q <= 1'b1;
								state_q <= S_CHK;
							end
						endcase
					end
					S_LD1: begin
						ld_x_q <= ld_x;
						state_q <= S_LD2;
					end
					S_LD2: begin
						w_q <= '{year: req_q.in_year, month: req_q.in_month,
							day: req_q.in_day, wd: r7[2:0]};
						cur_q <= '{year: req_q.in_year, month: req_q.in_month,
							day: req_q.in_day, wd: r7[2:0]};
						fin_q <= 1'b1;
						state_q <= S_CHK;
					end
					S_CAL: begin
						// one calendar day per cycle
						if (cnt_q == 10'd0) begin
							cur_q <= w_q;
							fin_q <= 1'b1;
							state_q <= S_CHK;
						end else if (stp_ok) begin
							w_q <= stp_next;
							cnt_q <= cnt_q - 10'd1;
						end else begin
							err_q <= 1'b1;
							w_q <= cur_q;
							fin_q <= 1'b1;
							state_q <= S_CHK;
						end
					end
					S_CHK: begin
						// weekdays need a holiday scan
						issuing_q <= 1'b1;
						ptr_q <= '0;
						hit_q <= 1'b0;
						state_q <= S_SCAN;
					end
					S_SCAN: begin
					end
					S_OUT: begin
						if (out_load) begin
							rsp_q <= '{out_year: cur_q.year, out_month: cur_q.month,
								out_day: cur_q.day, weekday: cur_q.wd,
								trading_day: trade_q, error: err_q};
							state_q <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

endmodule
